// ===== rtl/lsjc_pkg.sv =====
// lsjc_pkg: shared types and constants of the line-sensor junction classifier.
// No dependencies; used by lsjc_merge, the top level and the testbench.
package lsjc_pkg;

  // Sensors handled by one lane
  localparam int LANE_WIDTH = 4;

  // Fixed config field widths
  localparam int COUNT_CFG_W = 3;

  // Reset values of the configuration registers
  localparam int STRAIGHT_RESET   = 119;
  localparam int ISECT_CNT_RESET  = 6;
  localparam int TURN_CNT_RESET   = 7;

  typedef enum logic [2:0] {
    CLASS_STRAIGHT     = 3'd0,
    CLASS_INTERSECTION = 3'd1,
    CLASS_LEFT         = 3'd2,
    CLASS_RIGHT        = 3'd3,
    CLASS_DEAD_END     = 3'd4
  } road_class_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_e;

  typedef enum logic [1:0] {
    REG_STRAIGHT   = 2'd0,
    REG_ISECT_CNT  = 2'd1,
    REG_TURN_CNT   = 2'd2
  } cfg_idx_e;

  // Count thresholds handed to the merge stage
  typedef struct packed {
    logic [COUNT_CFG_W-1:0] isect_cnt;
    logic [COUNT_CFG_W-1:0] turn_cnt;
  } cfg_counts_t;

  // One result word
  typedef struct packed {
    logic        hold;
    turn_e       turn;
    road_class_e cls;
  } result_t;

endpackage

// ===== rtl/lsjc_lane.sv =====
// lsjc_lane: set-bit count and centered weighted sum over one slice of sensors.
// Depends on nothing but its parameters; instanced by the top level.
module lsjc_lane #(
  parameter int NBITS        = 4,
  parameter int BASE         = 0,
  parameter int SENSOR_COUNT = 7,
  parameter int CNT_W        = 3,
  parameter int SUM_W        = 7
) (
  input  logic [NBITS-1:0]        bits_i,
  output logic [CNT_W-1:0]        count_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int Mid = (SENSOR_COUNT - 1) / 2;

  always_comb begin
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] acc;
    cnt = '0;
    acc = '0;
    for (int j = 0; j < NBITS; j++) begin
      cnt = cnt + CNT_W'(bits_i[j]);
      if (bits_i[j]) begin
        acc = acc + $signed(SUM_W'(BASE + j - Mid));
      end
    end
    count_o = cnt;
    sum_o   = acc;
  end

endmodule

// ===== rtl/lsjc_merge.sv =====
// lsjc_merge: adds the lane partials, classifies the row and keeps the state.
// Depends on lsjc_pkg; fed by the lsjc_lane instances in the top level.
module lsjc_merge #(
  parameter int SENSOR_COUNT = 7,
  parameter int NUM_LANES    = 2,
  parameter int CNT_W        = 3,
  parameter int SUM_W        = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [SENSOR_COUNT-1:0]              row_i,
  input  logic [NUM_LANES-1:0][CNT_W-1:0]      lane_count_i,
  input  logic [NUM_LANES-1:0][SUM_W-1:0]      lane_sum_i,
  input  logic [SENSOR_COUNT-1:0]              pattern_i,
  input  lsjc_pkg::cfg_counts_t                counts_i,
  output lsjc_pkg::result_t                    result_o
);

  localparam int Mid = (SENSOR_COUNT - 1) / 2;

  logic [SENSOR_COUNT-1:0] prev_q;
  lsjc_pkg::road_class_e   class_q, class_d;
  lsjc_pkg::turn_e         turn_q, turn_d;
  logic                    hold_q, hold_d;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    count = '0;
    sum   = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      count = count + lane_count_i[l];
      sum   = sum + $signed(lane_sum_i[l]);
    end
  end

  always_comb begin
    class_d = class_q;
    turn_d  = turn_q;
    hold_d  = hold_q;
    if (!(row_i == prev_q && !hold_q)) begin
      if (!hold_q) begin
        if (turn_q == lsjc_pkg::TURN_NONE) begin
          priority if (32'(count) == Mid && !row_i[Mid]) begin
            if (sum > 0) begin
              turn_d = lsjc_pkg::TURN_LEFT;
            end else if (sum < 0) begin
              turn_d = lsjc_pkg::TURN_RIGHT;
            end
          end else if (count == '0) begin
            class_d = lsjc_pkg::CLASS_INTERSECTION;
            hold_d  = 1'b1;
          end else if (32'(count) == SENSOR_COUNT) begin
            class_d = lsjc_pkg::CLASS_DEAD_END;
            hold_d  = 1'b1;
          end else begin
            // no junction on this row
          end
        end else begin
          priority if (32'(count) == 32'(counts_i.isect_cnt)) begin
            class_d = lsjc_pkg::CLASS_INTERSECTION;
            hold_d  = 1'b1;
          end else if (32'(count) == 32'(counts_i.turn_cnt)) begin
            unique case (turn_q)
              lsjc_pkg::TURN_LEFT:  class_d = lsjc_pkg::CLASS_LEFT;
              lsjc_pkg::TURN_RIGHT: class_d = lsjc_pkg::CLASS_RIGHT;
              default:              class_d = lsjc_pkg::CLASS_STRAIGHT;
            endcase
            hold_d = 1'b1;
          end else begin
            // count matches neither threshold, turn stays pending
          end
        end
      end
      // straight pattern on two rows in a row releases the hold
      if (hold_d && prev_q == pattern_i && row_i == pattern_i) begin
        hold_d  = 1'b0;
        class_d = lsjc_pkg::CLASS_STRAIGHT;
        turn_d  = lsjc_pkg::TURN_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= SENSOR_COUNT'(lsjc_pkg::STRAIGHT_RESET);
      class_q <= lsjc_pkg::CLASS_STRAIGHT;
      turn_q  <= lsjc_pkg::TURN_NONE;
      hold_q  <= 1'b0;
    end else if (accept_i) begin
      prev_q  <= row_i;
      class_q <= class_d;
      turn_q  <= turn_d;
      hold_q  <= hold_d;
    end
  end

  assign result_o = '{hold: hold_d, turn: turn_d, cls: class_d};

endmodule

// ===== rtl/line_sensor_junction_classifier.sv =====
// line_sensor_junction_classifier: top level, lanes, config registers, output skid.
// Depends on lsjc_pkg, lsjc_lane and lsjc_merge.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid_i/tready_o      | tdata: sensor_bits
//  m_axis   | out | m_axis_tvalid_o/tready_i      | tdata: road_class, pending_turn,
//           |     |                               |        awaiting_straight
//  cfg      | in  | cfg_valid_i/cfg_ready_o       | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while m_axis does not stall; results are registered.
// The lane adders and the classifier in lsjc_merge are combinational logic.
// Reset: config returns to straight 119, counts 6 and 7; state to straight/none.
// A two-word output buffer (main register plus skid) lets a row be taken while a
// result waits; s_axis_tready_o drops only once both entries are full.
// cfg is always ready; writes are meant for idle periods only.
module line_sensor_junction_classifier #(
  parameter int SENSOR_COUNT = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // bits [SENSOR_COUNT-1:0] sensor_bits, rest zero
  input  logic [((SENSOR_COUNT+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [2:0] road_class, [4:3] pending_turn, [5] awaiting_straight, [7:6] zero
  output logic [7:0]              m_axis_tdata_o,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [SENSOR_COUNT-1:0] cfg_data_i
);

  localparam int NumLanes = (SENSOR_COUNT + lsjc_pkg::LANE_WIDTH - 1) / lsjc_pkg::LANE_WIDTH;
  localparam int CntW     = $clog2(SENSOR_COUNT + 1);
  localparam int SumW     = $clog2(SENSOR_COUNT * SENSOR_COUNT + 1) + 1;

  // Configuration registers
  logic [SENSOR_COUNT-1:0] pattern_q;
  lsjc_pkg::cfg_counts_t   counts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q          <= SENSOR_COUNT'(lsjc_pkg::STRAIGHT_RESET);
      counts_q.isect_cnt <= lsjc_pkg::COUNT_CFG_W'(lsjc_pkg::ISECT_CNT_RESET);
      counts_q.turn_cnt  <= lsjc_pkg::COUNT_CFG_W'(lsjc_pkg::TURN_CNT_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lsjc_pkg::cfg_idx_e'(cfg_index_i))
        lsjc_pkg::REG_STRAIGHT:  pattern_q          <= cfg_data_i;
        lsjc_pkg::REG_ISECT_CNT: counts_q.isect_cnt <= cfg_data_i[lsjc_pkg::COUNT_CFG_W-1:0];
        lsjc_pkg::REG_TURN_CNT:  counts_q.turn_cnt  <= cfg_data_i[lsjc_pkg::COUNT_CFG_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Input row; bits above the sensor count are ignored
  logic [SENSOR_COUNT-1:0] row;
  logic                    in_accept;

  assign row       = s_axis_tdata_i[SENSOR_COUNT-1:0];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // Lanes: each takes LANE_WIDTH sensors, the last one what is left
  logic [NumLanes-1:0][CntW-1:0] lane_count;
  logic [NumLanes-1:0][SumW-1:0] lane_sum;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam int Base  = l * lsjc_pkg::LANE_WIDTH;
    localparam int NBits = (SENSOR_COUNT - Base < lsjc_pkg::LANE_WIDTH) ?
                           (SENSOR_COUNT - Base) : lsjc_pkg::LANE_WIDTH;
    lsjc_lane #(
      .NBITS       (NBits),
      .BASE        (Base),
      .SENSOR_COUNT(SENSOR_COUNT),
      .CNT_W       (CntW),
      .SUM_W       (SumW)
    ) u_lane (
      .bits_i (row[Base +: NBits]),
      .count_o(lane_count[l]),
      .sum_o  (lane_sum[l])
    );
  end

  // Merge: totals, classification, state
  lsjc_pkg::result_t result;

  lsjc_merge #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .NUM_LANES   (NumLanes),
    .CNT_W       (CntW),
    .SUM_W       (SumW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .row_i       (row),
    .lane_count_i(lane_count),
    .lane_sum_i  (lane_sum),
    .pattern_i   (pattern_q),
    .counts_i    (counts_q),
    .result_o    (result)
  );

  // Output buffer: main register feeds the port, skid catches a word on stall
  lsjc_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              out_take;

  assign out_take        = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_take) begin
        out_valid_q  <= skid_valid_q || in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : result;
    end
    if (in_accept && !skid_valid_q) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.hold, out_q.turn, out_q.cls};

  // A skid word never exists without a word in the main register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while the output register is empty");

  // A held class is never straight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hold) |-> (out_q.cls != lsjc_pkg::CLASS_STRAIGHT))
    else $error("hold flag set with a straight class");

  // Without a hold the class is straight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hold) |-> (out_q.cls == lsjc_pkg::CLASS_STRAIGHT))
    else $error("non-straight class without a hold");

  // A pending skid word moves up when the main word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && skid_valid_q) |=> out_valid_q)
    else $error("skid word lost on output handshake");

endmodule

// ===== tb/sv/tb_line_sensor_junction_classifier.sv =====
// tb_line_sensor_junction_classifier: self-checking bench for the junction classifier.
// Needs lsjc_pkg and the line_sensor_junction_classifier RTL; nothing else.
// Rows go in over s_axis with bursty valid; results are scored against a local predictor.
`timescale 1ns / 100ps

module tb_line_sensor_junction_classifier;
  import lsjc_pkg::*;

  localparam int SENSOR_COUNT = 7;
  localparam int MID_SENSOR   = (SENSOR_COUNT - 1) / 2;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int ROWS_PER_SET = 72;
  // index 3 decodes to no register; writes there must be dropped
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [6:0] ROW_EMPTY     = 7'h00;
  localparam logic [6:0] ROW_FULL      = 7'h7F;

  // ---------------------------------------------------------------------------
  // Expected-result store with its own copy of the classifier state
  // ---------------------------------------------------------------------------
  class junction_scoreboard;
    logic [6:0]  straight_row;
    logic [2:0]  isect_cnt;
    logic [2:0]  turn_cnt;
    logic [6:0]  last_row;
    road_class_e cls;
    turn_e       turn;
    logic        hold;
    result_t     expected_q[$];
    int          errors;
    int          checked;

    function void reset_state();
      straight_row = 7'(STRAIGHT_RESET);
      isect_cnt    = 3'(ISECT_CNT_RESET);
      turn_cnt     = 3'(TURN_CNT_RESET);
      last_row     = 7'(STRAIGHT_RESET);
      cls          = CLASS_STRAIGHT;
      turn         = TURN_NONE;
      hold         = 1'b0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] value);
      case (idx)
        REG_STRAIGHT:  straight_row = value;
        REG_ISECT_CNT: isect_cnt = value[2:0];
        REG_TURN_CNT:  turn_cnt = value[2:0];
        default: ;
      endcase
    endfunction

    // Advance the classifier by one accepted row and queue the result word
    function void note_row(logic [6:0] row);
      int ones;
      int weight;
      result_t exp_word;
      ones = 0;
      weight = 0;
      // an unchanged row while nothing is held leaves the state alone
      if (!(row == last_row && !hold)) begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (row[i]) begin
            ones++;
            weight += i - MID_SENSOR;
          end
        end
        if (!hold) begin
          if (turn == TURN_NONE) begin
            if (ones == MID_SENSOR && !row[MID_SENSOR]) begin
              if (weight > 0) turn = TURN_LEFT;
              else if (weight < 0) turn = TURN_RIGHT;
            end else if (ones == 0) begin
              cls = CLASS_INTERSECTION;
              hold = 1'b1;
            end else if (ones == SENSOR_COUNT) begin
              cls = CLASS_DEAD_END;
              hold = 1'b1;
            end
          end else begin
            if (ones == isect_cnt) begin
              cls = CLASS_INTERSECTION;
              hold = 1'b1;
            end else if (ones == turn_cnt) begin
              cls = (turn == TURN_LEFT) ? CLASS_LEFT : CLASS_RIGHT;
              hold = 1'b1;
            end
          end
        end
        // two straight rows in a row release the hold
        if (hold && last_row == straight_row && row == straight_row) begin
          hold = 1'b0;
          cls = CLASS_STRAIGHT;
          turn = TURN_NONE;
        end
      end
      last_row = row;
      exp_word.cls  = cls;
      exp_word.turn = turn;
      exp_word.hold = hold;
      expected_q = {expected_q, exp_word};
    endfunction

    function void check_result(logic [7:0] word);
      result_t exp_word;
      result_t got;
      got = word[5:0];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result word 0x%02h with nothing expected", $time, word);
        return;
      end
      exp_word = expected_q.pop_front();
      checked++;
      if (got.cls !== exp_word.cls || got.turn !== exp_word.turn ||
          got.hold !== exp_word.hold || word[7:6] !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] word %0d: class %0d/%0d turn %0d/%0d hold %0d/%0d pad %b (exp/got)",
                   $time, checked, exp_word.cls, got.cls, exp_word.turn, got.turn,
                   exp_word.hold, got.hold, word[7:6]);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic [7:0] s_tdata     = 8'h00;   // [6:0] sensor_bits, [7] zero
  logic       s_tvalid    = 1'b0;
  logic       s_tready;
  logic [7:0] m_tdata;               // [2:0] class, [4:3] turn, [5] hold, [7:6] zero
  logic       m_tvalid;
  logic       m_tready    = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index   = REG_STRAIGHT;
  logic [6:0] cfg_data    = 7'h00;

  junction_scoreboard sb = new;

  int burst_left = 0;
  int rows_sent  = 0;
  int reg_sets   = 0;
  int cycles     = 0;

  always #4 clk = ~clk;

  line_sensor_junction_classifier #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a 16-bit pattern that is re-rolled every span.
  // Spans cover always-ready, random, mostly-stalled and mostly-ready behavior.
  // ---------------------------------------------------------------------------
  int          rx_span  = 0;
  int          rx_phase = 0;
  logic [15:0] rx_pattern;

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_span = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: rx_pattern = 16'hFFFF;
        1: rx_pattern = 16'($urandom);
        2: rx_pattern = 16'($urandom & $urandom & $urandom);
        default: rx_pattern = 16'($urandom | $urandom);
      endcase
      if (rx_pattern == 16'h0000) rx_pattern = 16'h8000;
    end
    rx_span--;
    m_tready <= rx_pattern[rx_phase[3:0]];
    rx_phase++;
  end

  // Score every result word taken at this edge
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               sb.expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Push one row; valid comes in bursts with random gaps in between
  task automatic send_row(input logic [6:0] row);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row};
    do @(posedge clk); while (!s_tready);
    sb.note_row(row);
    rows_sent++;
  endtask

  // Hold off the sender until every queued result word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Write all registers plus the spare index; counts carry junk upper bits
  task automatic program_regs(input logic [6:0] pattern, input logic [2:0] isect,
                              input logic [2:0] tcnt);
    logic [1:0] idx[4];
    logic [6:0] val[4];
    idx = '{REG_STRAIGHT, REG_ISECT_CNT, REG_TURN_CNT, CFG_IDX_SPARE};
    val = '{pattern, {4'($urandom), isect}, {4'($urandom), tcnt}, 7'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    reg_sets++;
  endtask

  // Random row with exactly n bits set; optionally keeps the middle sensor clear
  function automatic logic [6:0] rand_row(int n, bit skip_mid);
    logic [6:0] row;
    int b;
    int ones;
    row = '0;
    ones = 0;
    while (ones < n) begin
      b = skip_mid ? $urandom_range(0, SENSOR_COUNT - 2) : $urandom_range(0, SENSOR_COUNT - 1);
      if (skip_mid && b >= MID_SENSOR) b++;
      if (!row[b]) begin
        row[b] = 1'b1;
        ones++;
      end
    end
    return row;
  endfunction

  // One road situation: mostly well-formed junctions, some noise and broken runs
  task automatic play_episode();
    logic [6:0] row;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      // straight, candidate turn, confirm by count, then back to straight
      repeat ($urandom_range(0, 2)) send_row(sb.straight_row);
      send_row(rand_row(MID_SENSOR, 1'b1));
      if ($urandom_range(0, 2) == 0) send_row(7'($urandom));
      send_row(rand_row($urandom_range(0, 1) ? sb.isect_cnt : sb.turn_cnt, 1'b0));
      repeat ($urandom_range(0, 2)) send_row(7'($urandom));
      send_row(sb.straight_row);
      send_row(sb.straight_row);
    end else if (pick == 5) begin
      repeat ($urandom_range(1, 2)) send_row(ROW_EMPTY);
      send_row(sb.straight_row);
      send_row(sb.straight_row);
    end else if (pick == 6) begin
      send_row(ROW_FULL);
      send_row(7'($urandom));
      send_row(sb.straight_row);
      send_row(sb.straight_row);
    end else if (pick == 7) begin
      repeat ($urandom_range(1, 6)) send_row(7'($urandom));
    end else if (pick == 8) begin
      // turn candidate, then rows of random count that need not confirm it, then one straight row
      send_row(rand_row(MID_SENSOR, 1'b1));
      repeat ($urandom_range(1, 3)) send_row(rand_row($urandom_range(1, 6), 1'b0));
      send_row(sb.straight_row);
    end else begin
      row = 7'($urandom);
      repeat ($urandom_range(2, 4)) send_row(row);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [6:0] directed[$];
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass on the reset settings: idle repeat, intersection, release,
    // dead end, a left turn confirmed, a right turn ended by an intersection
    // while it is pending, a zero-sum turn candidate, and the all-ones row.
    directed = '{7'b1110111, 7'b0000000, 7'b0000000, 7'b1110111, 7'b1110111,
                 7'b1111111, 7'b1110111, 7'b1110111, 7'b1110000, 7'b1111111,
                 7'b1110111, 7'b1110111, 7'b0000111, 7'b1110111, 7'b1110111,
                 7'b0110001, 7'b1111111, 7'b1110111, 7'b1110111, 7'b0001000};
    foreach (directed[k]) send_row(directed[k]);

    // Register settings: reset values, both extremes, then random ones.
    // The pause before each write also covers the drained-queue case.
    for (int p = 0; p < 6; p++) begin
      int start_rows;
      drain_results();
      case (p)
        0: program_regs(7'(STRAIGHT_RESET), 3'(ISECT_CNT_RESET), 3'(TURN_CNT_RESET));
        1: program_regs(7'h00, 3'd0, 3'd0);
        2: program_regs(7'h7F, 3'd7, 3'd7);
        default: program_regs(7'($urandom), 3'($urandom), 3'($urandom));
      endcase
      start_rows = rows_sent;
      while (rows_sent - start_rows < ROWS_PER_SET) play_episode();
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("Drove %0d sensor rows under %0d register settings; %0d result words scored",
             rows_sent, reg_sets, sb.checked);
    $display("Failing words: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
